/* design/i2c_master_transaction_engine_assert.svh */
// Assertion macros for the I2C master transaction engine checker.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_ASSERT_SVH
// Implication checked every clock, disabled in reset.
`define IMTE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define IMTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* design/imte_pkg.sv */
// Shared types and constants of the I2C master transaction engine.
`timescale 1ns / 1ps
`default_nettype none
package imte_pkg;
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;
  localparam logic [2:0] KIND_WRITE  = 3'd0;
  localparam logic [2:0] KIND_READ   = 3'd1;
  localparam logic [2:0] KIND_REG_WR = 3'd2;
  localparam logic [2:0] KIND_REG_RD = 3'd3;
  localparam logic [2:0] KIND_PROBE  = 3'd4;
  localparam logic [15:0] DEFAULT_TICKS = 16'd20;
  localparam logic [0:0] CFG_ADDR  = 1'b0;
  localparam logic [0:0] CFG_TICKS = 1'b1;
  localparam int QDEPTH = 2;

  // Classified word passed from front to back.
  typedef struct packed {
    logic       is_tick;
    logic       is_begin;
    logic       is_data;
    logic [2:0] kind;
    logic [7:0] reg_num;
    logic [7:0] count;
    logic [7:0] wbyte;
    logic       sda;
  } item_t;

  // Result word.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rbyte;
    logic       rvalid;
    logic       want;
    logic       fin;
    logic       status;
    logic       busy;
  } result_t;
endpackage
`default_nettype wire

/* design/imte_front.sv */
// Front end: accepts input words, classifies them and queues them.
`timescale 1ns / 1ps
`default_nettype none
module imte_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       operation,
  input  wire logic [2:0]       command_kind,
  input  wire logic [7:0]       register_number,
  input  wire logic [7:0]       byte_count,
  input  wire logic [7:0]       write_byte,
  input  wire logic             sda_sample,
  output logic                  q_valid,
  output imte_pkg::item_t       q_item,
  input  wire logic             q_take
);
  import imte_pkg::*;

  item_t      mem [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;
  logic       pop;

  // Classify the incoming word; operation 3 acts as a tick.
  always_comb begin
    cls.is_begin = (operation == OP_BEGIN);
    cls.is_data  = (operation == OP_DATA);
    cls.is_tick  = !(cls.is_begin || cls.is_data);
    cls.kind     = command_kind;
    cls.reg_num  = register_number;
    cls.count    = byte_count;
    cls.wbyte    = write_byte;
    cls.sda      = sda_sample;
  end

  assign in_stall = (count == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = mem[rd_ptr];

  // Hold queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  // Advance queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* design/imte_back.sv */
// Back end: bus sequencer, one queued word per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module imte_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [0:0]      cfg_idx,
  input  wire logic [15:0]     cfg_data,
  input  wire logic            q_valid,
  input  wire imte_pkg::item_t q_item,
  output logic                 q_take,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output imte_pkg::result_t    res
);
  import imte_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_START_A, S_START_B, S_START_C, S_WBIT_A, S_WBIT_B, S_WBIT_C,
    S_CHK_A, S_CHK_B, S_CHK_C, S_RBIT_A, S_RBIT_B, S_MACK_A, S_MACK_B,
    S_MACK_C, S_STOP, S_WAIT_DATA
  } step_t;
  typedef enum logic [1:0] {R_ADDR_W, R_ADDR_R, R_REG, R_DATA} role_t;

  logic [6:0]  dev_addr;
  logic [15:0] ticks;
  step_t       step, step_next;
  logic [15:0] timer, timer_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [2:0]  kind, kind_next;
  logic [7:0]  act_reg, act_reg_next;
  logic [1:0]  drive, drive_next;
  role_t       role, role_next;
  logic        nack, nack_next;
  logic        err, err_next;
  result_t     res_next;
  logic [15:0] load;
  logic        adv;

  assign load   = (ticks == 16'd0) ? 16'd1 : ticks;
  assign adv    = !out_valid || !out_stall;
  assign q_take = adv;

  // Compute the next sequencer state for the queued word.
  always_comb begin
    step_next       = step;
    timer_next      = timer;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    bytes_left_next = bytes_left;
    kind_next       = kind;
    act_reg_next    = act_reg;
    drive_next      = drive;
    role_next       = role;
    nack_next       = nack;
    err_next        = err;
    res_next        = '0;
    if (q_item.is_begin) begin
      if (step == S_IDLE && q_item.kind <= KIND_PROBE) begin
        kind_next       = q_item.kind;
        act_reg_next    = q_item.reg_num;
        bytes_left_next = q_item.count;
        nack_next       = 1'b0;
        err_next        = 1'b0;
        role_next       = (q_item.kind == KIND_READ) ? R_ADDR_R : R_ADDR_W;
        step_next       = S_START_A;
        drive_next      = 2'b11;
        timer_next      = load;
      end
    end else if (q_item.is_data) begin
      if (step == S_WAIT_DATA) begin
        if (bytes_left != 8'd0) bytes_left_next = bytes_left - 8'd1;
        shift_byte_next = q_item.wbyte;
        bit_index_next  = 3'd0;
        role_next       = R_DATA;
        step_next       = S_WBIT_A;
        drive_next      = {1'b0, q_item.wbyte[7]};
        timer_next      = load;
      end
    end else if (step != S_IDLE && step != S_WAIT_DATA) begin
      if (timer > 16'd1) begin
        timer_next = timer - 16'd1;
      end else begin
        timer_next = load;
        case (step)
          S_START_A: begin
            step_next = S_START_B; drive_next = 2'b10;
          end
          S_START_B: begin
            step_next = S_START_C; drive_next = 2'b00;
          end
          S_START_C: begin
            shift_byte_next = {dev_addr, role == R_ADDR_R};
            bit_index_next  = 3'd0;
            step_next       = S_WBIT_A;
            drive_next      = {1'b0, dev_addr[6]};
          end
          S_WBIT_A: begin
            step_next = S_WBIT_B; drive_next = {1'b1, shift_byte[7]};
          end
          S_WBIT_B: begin
            step_next  = S_WBIT_C;
            drive_next = {1'b0, (bit_index == 3'd7) ? 1'b1 : shift_byte[7]};
          end
          S_WBIT_C: begin
            if (bit_index == 3'd7) begin
              step_next = S_CHK_A; drive_next = 2'b01;
            end else begin
              shift_byte_next = {shift_byte[6:0], 1'b0};
              bit_index_next  = bit_index + 3'd1;
              step_next       = S_WBIT_A;
              drive_next      = {1'b0, shift_byte[6]};
            end
          end
          S_CHK_A: begin
            step_next = S_CHK_B; drive_next = 2'b11;
          end
          S_CHK_B: begin
            nack_next = q_item.sda; step_next = S_CHK_C; drive_next = 2'b01;
          end
          S_CHK_C: begin
            // Decide what follows the acknowledge slot by byte role.
            case (role)
              R_ADDR_W: begin
                if (kind == KIND_PROBE) begin
                  err_next = nack; step_next = S_STOP; drive_next = 2'b10;
                end else if (kind == KIND_WRITE && nack) begin
                  step_next = S_IDLE; timer_next = '0;
                  res_next.fin = 1'b1; res_next.status = 1'b1;
                end else if (kind == KIND_WRITE) begin
                  if (bytes_left == 8'd0) begin
                    err_next = 1'b0; step_next = S_STOP; drive_next = 2'b10;
                  end else begin
                    step_next = S_WAIT_DATA; timer_next = '0;
                  end
                end else begin
                  shift_byte_next = act_reg;
                  bit_index_next  = 3'd0;
                  role_next       = R_REG;
                  step_next       = S_WBIT_A;
                  drive_next      = {1'b0, act_reg[7]};
                end
              end
              R_ADDR_R: begin
                if (nack) begin
                  step_next = S_IDLE; timer_next = '0;
                  res_next.fin = 1'b1; res_next.status = 1'b1;
                end else if (bytes_left == 8'd0) begin
                  err_next = 1'b0; step_next = S_STOP; drive_next = 2'b10;
                end else begin
                  bit_index_next = 3'd0; shift_byte_next = '0;
                  step_next = S_RBIT_A; drive_next = 2'b11;
                end
              end
              R_REG: begin
                if (kind == KIND_REG_RD || bytes_left == 8'd0) begin
                  err_next = 1'b0; step_next = S_STOP; drive_next = 2'b10;
                end else begin
                  step_next = S_WAIT_DATA; timer_next = '0;
                end
              end
              default: begin
                if (nack || bytes_left == 8'd0) begin
                  err_next = nack; step_next = S_STOP; drive_next = 2'b10;
                end else begin
                  step_next = S_WAIT_DATA; timer_next = '0;
                end
              end
            endcase
          end
          S_RBIT_A: begin
            shift_byte_next = {shift_byte[6:0], q_item.sda};
            step_next = S_RBIT_B; drive_next = 2'b01;
          end
          S_RBIT_B: begin
            if (bit_index == 3'd7) begin
              res_next.rbyte  = shift_byte;
              res_next.rvalid = 1'b1;
              bytes_left_next = (bytes_left != 8'd0) ? bytes_left - 8'd1 : 8'd0;
              step_next       = S_MACK_A;
              drive_next      = {1'b0, bytes_left_next == 8'd0};
            end else begin
              bit_index_next = bit_index + 3'd1;
              step_next = S_RBIT_A; drive_next = 2'b11;
            end
          end
          S_MACK_A: begin
            step_next = S_MACK_B; drive_next = {1'b1, bytes_left == 8'd0};
          end
          S_MACK_B: begin
            step_next = S_MACK_C; drive_next = {1'b0, bytes_left == 8'd0};
          end
          S_MACK_C: begin
            if (bytes_left != 8'd0) begin
              bit_index_next = 3'd0; shift_byte_next = '0;
              step_next = S_RBIT_A; drive_next = 2'b11;
            end else begin
              err_next = 1'b0; step_next = S_STOP; drive_next = 2'b10;
            end
          end
          S_STOP: begin
            drive_next = 2'b11;
            if (kind == KIND_REG_RD && role == R_REG) begin
              role_next = R_ADDR_R; step_next = S_START_A;
            end else begin
              step_next = S_IDLE; timer_next = '0;
              res_next.fin = 1'b1; res_next.status = err;
            end
          end
          default: begin
            step_next = S_IDLE; timer_next = '0;
          end
        endcase
      end
    end
    res_next.scl  = drive_next[1];
    res_next.sda  = drive_next[0];
    res_next.want = (step_next == S_WAIT_DATA);
    res_next.busy = (step_next != S_IDLE);
  end

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= '0;
      ticks    <= DEFAULT_TICKS;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_ADDR) dev_addr <= cfg_data[6:0];
      else ticks <= cfg_data;
    end
  end

  // Advance the sequencer and register the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= S_IDLE;
      timer      <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      bytes_left <= '0;
      kind       <= '0;
      act_reg    <= '0;
      drive      <= 2'b11;
      role       <= R_ADDR_W;
      nack       <= 1'b0;
      err        <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      out_valid <= q_valid;
      if (q_valid) begin
        step       <= step_next;
        timer      <= timer_next;
        bit_index  <= bit_index_next;
        shift_byte <= shift_byte_next;
        bytes_left <= bytes_left_next;
        kind       <= kind_next;
        act_reg    <= act_reg_next;
        drive      <= drive_next;
        role       <= role_next;
        nack       <= nack_next;
        err        <= err_next;
      end
    end
  end

  // Hold the result payload while stalled.
  always_ff @(posedge clk) begin
    if (adv && q_valid) res <= res_next;
  end
endmodule
`default_nettype wire

/* design/i2c_master_transaction_engine.sv */
// Top level of the I2C master transaction engine.
// A word accepted enters a two-entry input queue; the sequencer takes it from there,
// and its result word is registered in one result register.
// Throughput: one word per cycle unless out_stall is high; the sequencer then holds.
// Reset: synchronous rst empties the queue and idles the sequencer, drives released,
// address 0 and 20 ticks per phase.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_transaction_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_idx,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [2:0]  command_kind,
  input  wire logic [7:0]  register_number,
  input  wire logic [7:0]  byte_count,
  input  wire logic [7:0]  write_byte,
  input  wire logic        sda_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             scl_release,
  output logic             sda_release,
  output logic [7:0]       read_byte,
  output logic             read_valid,
  output logic             want_data,
  output logic             finished,
  output logic             status_code,
  output logic             busy_res
);
  import imte_pkg::*;

  logic    q_valid;
  logic    q_take;
  item_t   q_item;
  result_t res;

  imte_front u_front (
    .clk, .rst, .in_valid, .in_stall, .operation, .command_kind,
    .register_number, .byte_count, .write_byte, .sda_sample,
    .q_valid, .q_item, .q_take
  );

  imte_back u_back (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .q_valid, .q_item, .q_take,
    .out_valid, .out_stall, .res
  );

  assign scl_release = res.scl;
  assign sda_release = res.sda;
  assign read_byte   = res.rbyte;
  assign read_valid  = res.rvalid;
  assign want_data   = res.want;
  assign finished    = res.fin;
  assign status_code = res.status;
  assign busy_res    = res.busy;
endmodule
`default_nettype wire

/* design/imte_checker.sv */
// Port-level checker for the I2C master transaction engine, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_transaction_engine_assert.svh"
module imte_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       scl_release,
  input wire logic [7:0] read_byte,
  input wire logic       read_valid,
  input wire logic       want_data,
  input wire logic       finished,
  input wire logic       status_code,
  input wire logic       busy_res
);
  `IMTE_ASSERT_IMPL(a_fin_idle, out_valid && finished, !busy_res && !want_data)
  `IMTE_ASSERT_IMPL(a_want_busy, out_valid && want_data, busy_res && !scl_release)
  `IMTE_ASSERT_IMPL(a_status_fin, out_valid && status_code, finished)
  `IMTE_ASSERT_IMPL(a_rbyte_zero, out_valid && !read_valid, read_byte == 8'd0)
  `IMTE_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(finished))
endmodule

bind i2c_master_transaction_engine imte_checker u_checker (
  .clk, .rst, .out_valid, .out_stall, .scl_release, .read_byte, .read_valid,
  .want_data, .finished, .status_code, .busy_res
);
`default_nettype wire
